/* rtl/kdq_pkg.sv */
// Package for the keyed discovery queue: sizes, field layout, codes and shared types.
`timescale 1ns / 1ps
`default_nettype none
package kdq_pkg;

  localparam int DEPTH        = 16;
  localparam int PAYLOAD_BITS = 64;
  localparam int CNT_W        = $clog2(DEPTH + 1);

  // Fixed field widths of the stream words.
  localparam int FUNC_W  = 3;
  localparam int KEY_W   = 32;
  localparam int PAY_W   = 64;
  localparam int COUNT_W = 5;

  localparam int IN_RAW_W  = FUNC_W + KEY_W + PAY_W;
  localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = 1 + KEY_W + PAY_W + COUNT_W;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  // Bit positions inside the output word.
  localparam int OUT_KEY_LO   = 1;
  localparam int OUT_PAY_LO   = OUT_KEY_LO + KEY_W;
  localparam int OUT_COUNT_LO = OUT_PAY_LO + PAY_W;

  localparam logic [FUNC_W-1:0] FN_INSERT_HEAD = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE_TAIL = 3'd1;
  localparam logic [FUNC_W-1:0] FN_VIEW_TAIL   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_REMOVE_KEY  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_VIEW_KEY    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_REPLACE_KEY = 3'd5;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [PAYLOAD_BITS-1:0] pay;
  } entry_t;

  // Command broadcast from the sequencer to every cell.
  typedef struct packed {
    logic                    cmp;        // compare the request key, latch match flags
    logic                    shift_in;   // take the left neighbor's entry (insert at head)
    logic                    shift_out;  // cells at or past the hit take the right entry
    logic                    write_sel;  // the first hit rewrites its payload
    logic [KEY_W-1:0]        key;
    logic [PAYLOAD_BITS-1:0] pay;
  } cell_ctl_t;

endpackage : kdq_pkg
`default_nettype wire

/* rtl/keyed_discovery_queue_unit.sv */
// Top level of the keyed discovery queue: request sequencer, cell chain and result register.
//
// The block keeps an ordered list of up to DEPTH entries (key plus payload),
// position 0 being the head. Requests arrive on the in_ stream, one word each:
// insert at head, remove or view the tail, remove or view the entry nearest
// the head with a given key, or replace that entry's payload (inserting at the
// head when the key is absent). Every request produces exactly one word on the
// out_ stream: a success flag, the entry read or removed, and the live count.
// A request is taken when in_tvalid and in_tready are both high.
// Timing: the cycle after acceptance every cell compares its key against the
// request in parallel and the hit nearest the head is marked along the chain;
// then, once the result register is free, the execute step applies the shift,
// rewrite or count change and loads the result register. A new request is
// accepted only while the block is idle or in the cycle its predecessor executes.
// When the receiver stalls, the finished result stays in the output register;
// the following request is still accepted and compared, and its execute step
// waits until the register is taken, so in_tready stays low meanwhile.
// Reset (rst_n low, synchronous) empties the queue and drops any pending word.
`timescale 1ns / 1ps
`default_nettype none
module keyed_discovery_queue_unit
  import kdq_pkg::*;
(
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  // fields from bit 0 up: func[2:0], key[34:3], payload_in[98:35], zero fill
  input  wire  [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  wire              out_tready,
  // fields from bit 0 up: ok[0], key_out[32:1], payload_out[96:33], count[101:97], zero fill
  output logic [OUT_W-1:0] out_tdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_CMP, ST_EXEC} state_t;

  state_t                  state_r;
  logic [FUNC_W-1:0]       func_r;
  logic [KEY_W-1:0]        key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;

  logic                    out_valid_r;
  logic                    ok_r;
  logic [KEY_W-1:0]        key_out_r;
  logic [PAY_W-1:0]        pay_out_r;

  cell_ctl_t               ctl;
  entry_t                  new_ent;
  entry_t                  ent_q   [DEPTH];
  logic                    seen_c  [DEPTH];
  logic [DEPTH-1:0]        first_v;
  logic [DEPTH-1:0]        tail_v;

  logic                    in_fire;
  logic                    exec_go;
  logic                    found;
  logic                    full;
  logic                    empty;
  logic                    tail_mode;
  logic                    ok_nxt;
  logic                    read_nxt;
  entry_t                  rd_ent;

  assign exec_go   = (state_r == ST_EXEC) && (!out_valid_r || out_tready);
  assign in_tready = (state_r == ST_IDLE) || exec_go;
  assign in_fire   = in_tvalid && in_tready;

  assign found     = |first_v;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign tail_mode = (func_r == FN_REMOVE_TAIL) || (func_r == FN_VIEW_TAIL);

  assign new_ent.key = key_r;
  assign new_ent.pay = pay_r;

  // Per-request decode of the execute step.
  always_comb begin
    ctl           = '0;
    ctl.cmp       = (state_r == ST_CMP);
    ctl.key       = key_r;
    ctl.pay       = pay_r;
    ok_nxt        = 1'b0;
    read_nxt      = 1'b0;
    count_nxt     = count_r;
    unique case (func_r)
      FN_INSERT_HEAD: begin
        if (!full) begin
          ok_nxt       = 1'b1;
          ctl.shift_in = exec_go;
          count_nxt    = count_r + CNT_W'(1);
        end
      end
      FN_REMOVE_TAIL, FN_VIEW_TAIL: begin
        if (!empty) begin
          ok_nxt   = 1'b1;
          read_nxt = 1'b1;
          if (func_r == FN_REMOVE_TAIL) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      FN_REMOVE_KEY, FN_VIEW_KEY: begin
        if (found) begin
          ok_nxt   = 1'b1;
          read_nxt = 1'b1;
          if (func_r == FN_REMOVE_KEY) begin
            ctl.shift_out = exec_go;
            count_nxt     = count_r - CNT_W'(1);
          end
        end
      end
      FN_REPLACE_KEY: begin
        if (found) begin
          ok_nxt        = 1'b1;
          ctl.write_sel = exec_go;
        end else if (!full) begin
          ok_nxt       = 1'b1;
          ctl.shift_in = exec_go;
          count_nxt    = count_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // The chain: entries move right on insert and left on removal.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   seen_in;
    if (i == 0) begin : g_head
      assign left_e  = new_ent;
      assign seen_in = 1'b0;
    end else begin : g_body
      assign left_e  = ent_q[i-1];
      assign seen_in = seen_c[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_e = ent_q[i];
    end else begin : g_inner
      assign right_e = ent_q[i+1];
    end

    kdq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .valid_i (CNT_W'(i) < count_r),
      .tail_i  (CNT_W'(i) == (count_r - CNT_W'(1))),
      .seen_i  (seen_in),
      .left_i  (left_e),
      .right_i (right_e),
      .ent_o   (ent_q[i]),
      .seen_o  (seen_c[i]),
      .first_o (first_v[i]),
      .tail_o  (tail_v[i])
    );
  end

  // Read select: the tail cell or the first hit, each flag at most one-hot.
  always_comb begin
    rd_ent = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (tail_mode ? tail_v[i] : first_v[i]) begin
        rd_ent = rd_ent | ent_q[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A new result replaces the one being taken in the same cycle.
      if (exec_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            state_r <= ST_CMP;
          end
        end
        ST_CMP: begin
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          if (exec_go) begin
            state_r     <= in_fire ? ST_CMP : ST_IDLE;
            count_r     <= count_nxt;
            ok_r        <= ok_nxt;
            key_out_r   <= read_nxt ? rd_ent.key : '0;
            pay_out_r   <= read_nxt ? PAY_W'(rd_ent.pay) : '0;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
    if (in_fire) begin
      func_r <= in_tdata[FUNC_W-1:0];
      key_r  <= in_tdata[FUNC_W +: KEY_W];
      pay_r  <= in_tdata[FUNC_W + KEY_W +: PAYLOAD_BITS];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_W - OUT_RAW_W){1'b0}}, COUNT_W'(count_r), pay_out_r,
                       key_out_r, ok_r};

endmodule : keyed_discovery_queue_unit
`default_nettype wire

/* rtl/kdq_cell.sv */
// One storage cell of the queue chain: holds one entry and its search flags.
`timescale 1ns / 1ps
`default_nettype none
module kdq_cell
  import kdq_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  cell_ctl_t  ctl,
  input  wire        valid_i,  // this position lies below the live count
  input  wire        tail_i,   // this position is the tail
  input  wire        seen_i,   // a hit exists nearer the head
  input  entry_t     left_i,
  input  entry_t     right_i,
  output entry_t     ent_o,
  output logic       seen_o,
  output logic       first_o,
  output logic       tail_o
);

  entry_t ent_r;
  logic   first_r;
  logic   seen_r;
  logic   tail_r;
  logic   match;

  assign match   = valid_i && (ent_r.key == ctl.key);
  assign seen_o  = seen_i | match;
  assign ent_o   = ent_r;
  assign first_o = first_r;
  assign tail_o  = tail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b0;
      seen_r  <= 1'b0;
      tail_r  <= 1'b0;
    end else if (ctl.cmp) begin
      first_r <= match & ~seen_i;
      seen_r  <= seen_o;
      tail_r  <= tail_i;
    end
  end

  // Entry storage carries no reset; only positions below the count are read.
  always_ff @(posedge clk) begin
    if (ctl.shift_in) begin
      ent_r <= left_i;
    end else if (ctl.shift_out && seen_r) begin
      ent_r <= right_i;
    end else if (ctl.write_sel && first_r) begin
      ent_r.pay <= ctl.pay;
    end
  end

endmodule : kdq_cell
`default_nettype wire

/* rtl/kdq_checker.sv */
// Port-level assertions for the keyed discovery queue, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module kdq_checker
  import kdq_pkg::*;
(
  input wire             clk,
  input wire             rst_n,
  input wire             in_tvalid,
  input wire             in_tready,
  input wire             out_tvalid,
  input wire             out_tready,
  input wire [OUT_W-1:0] out_tdata
);

  logic             ok_w;
  logic [KEY_W-1:0] key_w;
  logic [PAY_W-1:0] pay_w;
  logic [COUNT_W-1:0] cnt_w;

  assign ok_w  = out_tdata[0];
  assign key_w = out_tdata[OUT_KEY_LO +: KEY_W];
  assign pay_w = out_tdata[OUT_PAY_LO +: PAY_W];
  assign cnt_w = out_tdata[OUT_COUNT_LO +: COUNT_W];

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // The compare step always separates two accepted requests.
  a_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("requests accepted in consecutive cycles");

  // A failed request carries no entry.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !ok_w |-> (key_w == '0) && (pay_w == '0))
    else $error("failed result carries entry data");

  // The reported count never passes the store depth.
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (cnt_w <= COUNT_W'(DEPTH)))
    else $error("count beyond depth");

  // When no result word shows and no request is taken over a window that spans the
  // compare and execute steps, nothing is in flight, so no result word may appear next.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(in_tvalid && in_tready) ##1
    !out_tvalid && !(in_tvalid && in_tready) ##1
    !out_tvalid && !(in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result word without request");

endmodule : kdq_checker

bind keyed_discovery_queue_unit kdq_checker u_kdq_checker (.*);
`default_nettype wire
